// ===== rtl/arts_pkg.sv =====
// ============================================================================
// arts_pkg: shared types and constants for the assembly region trimmer
// Holds the register codes, result codes, the job record between the front
// and back parts, and the configuration bundle.
// ============================================================================
package arts_pkg;

    localparam int POS_W   = 31;
    localparam int PAD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int JOBQ_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SNP_PADDING   = 3'd0,
        CFG_INDEL_PADDING = 3'd1,
        CFG_EXT_LIMIT     = 3'd2,
        CFG_EMIT_REF_CONF = 3'd3,
        CFG_NO_TRIM       = 3'd4,
        CFG_CONTIG_LENGTH = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_VERDICT = 3'd0,
        KIND_SUMMARY = 3'd1,
        KIND_VARIANT = 3'd2,
        KIND_MAXIMUM = 3'd3,
        KIND_IDEAL   = 3'd4,
        KIND_FINAL   = 3'd5,
        KIND_FLANK   = 3'd6
    } span_kind_t;

    typedef enum logic [1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_UNTRIMMED = 2'd1,
        STATUS_TRIMMED   = 2'd2
    } trim_status_t;

    typedef enum logic [0:0] {
        OP_HEADER  = 1'b0,
        OP_VARIANT = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_VAR,
        ST_MAX,
        ST_IDEAL,
        ST_FINAL,
        ST_PRE,
        ST_POST
    } back_state_t;

    // One classified item, with a snapshot of the region state after it.
    typedef struct packed {
        logic             is_hdr;
        logic             last;
        logic             ov;
        logic [POS_W-1:0] ps;
        logic [POS_W-1:0] pe;
        logic             span_valid;
        logic             non_snp;
        logic [POS_W-1:0] region_lo;
        logic [POS_W-1:0] region_hi;
        logic [POS_W-1:0] span_lo;
        logic [POS_W-1:0] span_hi;
    } arts_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } jobq_stat_t;

    typedef struct packed {
        logic [PAD_W-1:0] snp_padding;
        logic [PAD_W-1:0] indel_padding;
        logic [PAD_W-1:0] extension_limit;
        logic             emit_ref_confidence;
        logic             no_trim;
        logic [POS_W-1:0] contig_length;
    } arts_cfg_t;

endpackage

// ===== rtl/arts_front.sv =====
// ============================================================================
// arts_front: item intake and classification
// Keeps the region and the span of overlapping variants, judges each variant
// and hands a job record to the job queue.
// ============================================================================
module arts_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    operation,
    input  logic [arts_pkg::POS_W-1:0] pos_start,
    input  logic [arts_pkg::POS_W-1:0] pos_end,
    input  logic                    is_snp,
    input  logic                    last,
    output logic                    job_push,
    output arts_pkg::arts_job_t     job
);
    import arts_pkg::*;

    logic [POS_W-1:0] region_lo_reg, region_lo_next;
    logic [POS_W-1:0] region_hi_reg, region_hi_next;
    logic [POS_W-1:0] span_lo_reg, span_lo_next;
    logic [POS_W-1:0] span_hi_reg, span_hi_next;
    logic             span_valid_reg, span_valid_next;
    logic             non_snp_reg, non_snp_next;
    logic             ov;

    assign ov = (pos_start <= region_hi_reg) && (region_lo_reg <= pos_end);

    always_comb
    begin
        region_lo_next  = region_lo_reg;
        region_hi_next  = region_hi_reg;
        span_lo_next    = span_lo_reg;
        span_hi_next    = span_hi_reg;
        span_valid_next = span_valid_reg;
        non_snp_next    = non_snp_reg;
        if (operation == OP_HEADER)
        begin
            region_lo_next  = pos_start;
            region_hi_next  = pos_end;
            span_lo_next    = '0;
            span_hi_next    = '0;
            span_valid_next = 1'b0;
            non_snp_next    = 1'b0;
        end
        else if (ov)
        begin
            if (!is_snp)
            begin
                non_snp_next = 1'b1;
            end
            if (span_valid_reg)
            begin
                span_lo_next = (pos_start < span_lo_reg) ? pos_start : span_lo_reg;
                span_hi_next = (pos_end > span_hi_reg) ? pos_end : span_hi_reg;
            end
            else
            begin
                span_lo_next = pos_start;
                span_hi_next = pos_end;
            end
            span_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        job.is_hdr     = (operation == OP_HEADER);
        job.last       = last;
        job.ov         = ov;
        job.ps         = pos_start;
        job.pe         = pos_end;
        job.span_valid = span_valid_next;
        job.non_snp    = non_snp_next;
        job.region_lo  = region_lo_next;
        job.region_hi  = region_hi_next;
        job.span_lo    = span_lo_next;
        job.span_hi    = span_hi_next;
    end

    // A header that does not close the region produces no result.
    assign job_push = accept && ((operation == OP_VARIANT) || last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_lo_reg  <= '0;
            region_hi_reg  <= '0;
            span_lo_reg    <= '0;
            span_hi_reg    <= '0;
            span_valid_reg <= 1'b0;
            non_snp_reg    <= 1'b0;
        end
        else if (accept)
        begin
            region_lo_reg  <= region_lo_next;
            region_hi_reg  <= region_hi_next;
            span_lo_reg    <= span_lo_next;
            span_hi_reg    <= span_hi_next;
            span_valid_reg <= span_valid_next;
            non_snp_reg    <= non_snp_next;
        end
    end

endmodule

// ===== rtl/arts_jobq.sv =====
// ============================================================================
// arts_jobq: job queue between front and back
// A small circular queue of job records with full and empty status.
// ============================================================================
module arts_jobq
#(
    parameter int DEPTH = arts_pkg::JOBQ_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  arts_pkg::arts_job_t job_in,
    input  logic                pop,
    output arts_pkg::arts_job_t job_out,
    output arts_pkg::jobq_stat_t stat
);
    import arts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    arts_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && (count_reg != FULL_CNT);
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= job_in;
        end
    end

    assign job_out    = slot_reg[head_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

endmodule

// ===== rtl/arts_back.sv =====
// ============================================================================
// arts_back: result sequencer
// Takes job records, emits verdict and summary rows, and steps through the
// trimmed span rows one per cycle into the output register while it is free or popped.
// ============================================================================
module arts_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  arts_pkg::arts_cfg_t         cfg,
    input  arts_pkg::arts_job_t         job_in,
    input  logic                        job_empty,
    output logic                        job_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [2:0]                  span_kind,
    output logic                        in_region,
    output logic [1:0]                  status,
    output logic [arts_pkg::PAD_W-1:0]  padding_used,
    output logic [arts_pkg::POS_W-1:0]  span_start,
    output logic [arts_pkg::POS_W-1:0]  span_end,
    output logic                        end_of_run
);
    import arts_pkg::*;

    back_state_t      state_reg, state_next;
    arts_job_t        job_reg;
    logic [PAD_W-1:0] pad_reg;
    trim_status_t     sum_status_reg;
    logic [POS_W-1:0] max_lo_reg, max_hi_reg, id_lo_reg, id_hi_reg;
    logic [POS_W-1:0] fin_lo_reg, fin_hi_reg, c_lo_reg, c_hi_reg;
    logic             pre_reg, post_reg;

    logic             out_valid_reg;
    span_kind_t       out_kind_reg;
    logic             out_inr_reg;
    trim_status_t     out_status_reg;
    logic [PAD_W-1:0] out_pad_reg;
    logic [POS_W-1:0] out_start_reg, out_end_reg;
    logic             out_eor_reg;

    logic             slot_free, take, emit;
    span_kind_t       row_kind;
    logic             row_inr;
    trim_status_t     row_status;
    logic [PAD_W-1:0] row_pad, head_pad;
    logic [POS_W-1:0] row_start, row_end;
    logic             row_eor;

    // Expansion arithmetic, all from the held job.
    logic [POS_W-1:0] max_lo_c, max_hi_c, id_lo_c, id_hi_c, c_lo_c, c_hi_c;
    logic [POS_W:0]   max_sum, id_sum;
    logic [POS_W-1:0] fin_mid_lo, fin_mid_hi;

    assign slot_free = !out_valid_reg || pop;
    assign take      = (state_reg == ST_IDLE) && !job_empty && slot_free;
    assign job_pop   = take;
    assign head_pad  = job_in.non_snp ? cfg.indel_padding : cfg.snp_padding;

    always_comb
    begin
        max_lo_c = (job_reg.region_lo > POS_W'(cfg.extension_limit))
                 ? job_reg.region_lo - POS_W'(cfg.extension_limit) : POS_W'(1);
        max_sum  = {1'b0, job_reg.region_hi} + (POS_W+1)'(cfg.extension_limit);
        max_hi_c = (max_sum > {1'b0, cfg.contig_length})
                 ? cfg.contig_length : max_sum[POS_W-1:0];
        id_lo_c  = (job_reg.span_lo > POS_W'(pad_reg))
                 ? job_reg.span_lo - POS_W'(pad_reg) : POS_W'(1);
        id_sum   = {1'b0, job_reg.span_hi} + (POS_W+1)'(pad_reg);
        id_hi_c  = (id_sum > {1'b0, cfg.contig_length})
                 ? cfg.contig_length : id_sum[POS_W-1:0];
        c_lo_c   = job_reg.span_lo;
        c_hi_c   = job_reg.span_hi;
        if (cfg.emit_ref_confidence)
        begin
            if (job_reg.region_lo > job_reg.span_lo)
            begin
                c_lo_c = job_reg.region_lo;
            end
            if (job_reg.region_hi < job_reg.span_hi)
            begin
                c_hi_c = job_reg.region_hi;
            end
        end
        fin_mid_lo = (max_lo_reg > id_lo_reg) ? max_lo_reg : id_lo_reg;
        fin_mid_hi = (max_hi_reg < id_hi_reg) ? max_hi_reg : id_hi_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && !job_in.is_hdr && job_in.last)
                begin
                    if (!job_in.span_valid || cfg.no_trim)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_VAR;
                    end
                end
            end
            ST_SUM:   if (slot_free) state_next = ST_IDLE;
            ST_VAR:   if (slot_free) state_next = ST_MAX;
            ST_MAX:   if (slot_free) state_next = ST_IDEAL;
            ST_IDEAL: if (slot_free) state_next = ST_FINAL;
            ST_FINAL:
            begin
                if (slot_free)
                begin
                    state_next = pre_reg ? ST_PRE : (post_reg ? ST_POST : ST_IDLE);
                end
            end
            ST_PRE:   if (slot_free) state_next = post_reg ? ST_POST : ST_IDLE;
            ST_POST:  if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        emit       = slot_free;
        row_kind   = KIND_VARIANT;
        row_inr    = 1'b0;
        row_status = STATUS_TRIMMED;
        row_pad    = pad_reg;
        row_start  = '0;
        row_end    = '0;
        row_eor    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                emit    = take;
                row_pad = head_pad;
                if (job_in.is_hdr)
                begin
                    row_kind   = KIND_SUMMARY;
                    row_status = STATUS_NONE;
                    row_eor    = 1'b1;
                end
                else
                begin
                    row_kind   = KIND_VERDICT;
                    row_inr    = job_in.ov;
                    row_status = STATUS_NONE;
                    row_pad    = '0;
                    row_start  = job_in.ps;
                    row_end    = job_in.pe;
                end
            end
            ST_SUM:
            begin
                row_kind   = KIND_SUMMARY;
                row_status = sum_status_reg;
                row_eor    = 1'b1;
            end
            ST_VAR:
            begin
                row_start = job_reg.span_lo;
                row_end   = job_reg.span_hi;
            end
            ST_MAX:
            begin
                row_kind  = KIND_MAXIMUM;
                row_start = max_lo_reg;
                row_end   = max_hi_reg;
            end
            ST_IDEAL:
            begin
                row_kind  = KIND_IDEAL;
                row_start = id_lo_reg;
                row_end   = id_hi_reg;
            end
            ST_FINAL:
            begin
                row_kind  = KIND_FINAL;
                row_start = fin_lo_reg;
                row_end   = fin_hi_reg;
                row_eor   = !(pre_reg || post_reg);
            end
            ST_PRE:
            begin
                row_kind  = KIND_FLANK;
                row_start = job_reg.region_lo;
                row_end   = c_lo_reg - 1'b1;
                row_eor   = !post_reg;
            end
            ST_POST:
            begin
                row_kind  = KIND_FLANK;
                row_inr   = 1'b1;
                row_start = c_hi_reg + 1'b1;
                row_end   = job_reg.region_hi;
                row_eor   = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg        <= job_in;
            pad_reg        <= head_pad;
            sum_status_reg <= cfg.no_trim && job_in.span_valid ? STATUS_UNTRIMMED
                                                               : STATUS_NONE;
        end
        if ((state_reg == ST_VAR) && slot_free)
        begin
            max_lo_reg <= max_lo_c;
            max_hi_reg <= max_hi_c;
            id_lo_reg  <= id_lo_c;
            id_hi_reg  <= id_hi_c;
            c_lo_reg   <= c_lo_c;
            c_hi_reg   <= c_hi_c;
        end
        if ((state_reg == ST_MAX) && slot_free)
        begin
            fin_lo_reg <= (fin_mid_lo < job_reg.span_lo) ? fin_mid_lo : job_reg.span_lo;
            fin_hi_reg <= (fin_mid_hi > job_reg.span_hi) ? fin_mid_hi : job_reg.span_hi;
            pre_reg    <= job_reg.region_lo < c_lo_reg;
            post_reg   <= job_reg.region_hi > c_hi_reg;
        end
        if (emit)
        begin
            out_kind_reg   <= row_kind;
            out_inr_reg    <= row_inr;
            out_status_reg <= row_status;
            out_pad_reg    <= row_pad;
            out_start_reg  <= row_start;
            out_end_reg    <= row_end;
            out_eor_reg    <= row_eor;
        end
    end

    assign empty        = !out_valid_reg;
    assign span_kind    = out_kind_reg;
    assign in_region    = out_inr_reg;
    assign status       = out_status_reg;
    assign padding_used = out_pad_reg;
    assign span_start   = out_start_reg;
    assign span_end     = out_end_reg;
    assign end_of_run   = out_eor_reg;

endmodule

// ===== rtl/assembly_region_trim_spans_top.sv =====
// ============================================================================
// assembly_region_trim_spans_top: assembly region trimmer
// Judges variant items against a region and reports the trimmed spans.
// ============================================================================
// An accepted item's job goes into the job queue; the back sequencer takes it and registers
// its first result in the output register. Throughput: one item per cycle while results
// are taken; a closing item that trims gives up to seven results, one per cycle from the
// back sequencer. The job queue lets the front keep accepting while the back works.
// Reset clears the region state, the queues and the registers (contig length
// to its maximum); no clearing pass is needed.
module assembly_region_trim_spans_top
#(
    parameter int JOB_QUEUE_DEPTH = arts_pkg::JOBQ_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [arts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arts_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            operation,
    input  logic [arts_pkg::POS_W-1:0]      pos_start,
    input  logic [arts_pkg::POS_W-1:0]      pos_end,
    input  logic                            is_snp,
    input  logic                            last,
    output logic                            empty,
    input  logic                            pop,
    output logic [2:0]                      span_kind,
    output logic                            in_region,
    output logic [1:0]                      status,
    output logic [arts_pkg::PAD_W-1:0]      padding_used,
    output logic [arts_pkg::POS_W-1:0]      span_start,
    output logic [arts_pkg::POS_W-1:0]      span_end,
    output logic                            end_of_run
);
    import arts_pkg::*;

    arts_cfg_t  cfg_reg;
    arts_job_t  front_job, head_job;
    jobq_stat_t q_stat;
    logic       accept, job_push, job_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.snp_padding         <= '0;
            cfg_reg.indel_padding       <= '0;
            cfg_reg.extension_limit     <= '0;
            cfg_reg.emit_ref_confidence <= 1'b0;
            cfg_reg.no_trim             <= 1'b0;
            cfg_reg.contig_length       <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SNP_PADDING:   cfg_reg.snp_padding     <= cfg_data[PAD_W-1:0];
                CFG_INDEL_PADDING: cfg_reg.indel_padding   <= cfg_data[PAD_W-1:0];
                CFG_EXT_LIMIT:     cfg_reg.extension_limit <= cfg_data[PAD_W-1:0];
                CFG_EMIT_REF_CONF: cfg_reg.emit_ref_confidence <= cfg_data[0];
                CFG_NO_TRIM:       cfg_reg.no_trim         <= cfg_data[0];
                CFG_CONTIG_LENGTH: cfg_reg.contig_length   <= cfg_data[POS_W-1:0];
                default:           ;
            endcase
        end
    end

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    arts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .pos_start (pos_start),
        .pos_end   (pos_end),
        .is_snp    (is_snp),
        .last      (last),
        .job_push  (job_push),
        .job       (front_job)
    );

    arts_jobq #(.DEPTH(JOB_QUEUE_DEPTH)) u_jobq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (front_job),
        .pop     (job_pop),
        .job_out (head_job),
        .stat    (q_stat)
    );

    arts_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_in       (head_job),
        .job_empty    (q_stat.empty),
        .job_pop      (job_pop),
        .pop          (pop),
        .empty        (empty),
        .span_kind    (span_kind),
        .in_region    (in_region),
        .status       (status),
        .padding_used (padding_used),
        .span_start   (span_start),
        .span_end     (span_end),
        .end_of_run   (end_of_run)
    );

    // The job queue can never report full and empty together.
    a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("job queue full and empty at once");

    // A waiting result that is not taken stays available.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

    // Summary rows always close the run.
    a_summary_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && span_kind == KIND_SUMMARY) |-> end_of_run)
        else $error("summary row without end of run");

    // Verdict rows never carry a status or close a run.
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && span_kind == KIND_VERDICT) |-> (!end_of_run && status == STATUS_NONE))
        else $error("malformed verdict row");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench for the assembly region trimmer
// Streams region headers and variant items through the input queue, predicts
// every verdict, summary and trimmed span row, and checks the popped rows in
// order. Several register settings are applied between idle phases.
// ============================================================================
module tb;
    import arts_pkg::*;

    localparam longint       POS_MAX       = 64'h7FFF_FFFF;
    localparam logic [30:0]  POS_TOP       = 31'h7FFF_FFFF;
    localparam int           SETTLE_CYCLES = 8;
    localparam int           CYCLE_LIMIT   = 500000;
    localparam int           RANDOM_ITEMS  = 420;
    localparam int           PHASES        = 8;
    localparam int           REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [2:0]  kind;
        logic        inr;
        logic [1:0]  st;
        logic [15:0] pad;
        logic [30:0] s;
        logic [30:0] e;
        logic        eor;
    } trim_row_t;

    class trim_scoreboard;
        logic [15:0] snp_pad;
        logic [15:0] indel_pad;
        logic [15:0] ext_limit;
        logic        clip_to_region;
        logic        report_untrimmed;
        logic [30:0] contig_len;
        longint      reg_lo;
        longint      reg_hi;
        longint      vspan_lo;
        longint      vspan_hi;
        bit          vspan_valid;
        bit          non_snp_seen;
        trim_row_t   expected_rows[$];
        int          mismatches;

        function new();
            snp_pad = '0;
            indel_pad = '0;
            ext_limit = '0;
            clip_to_region = 1'b0;
            report_untrimmed = 1'b0;
            contig_len = POS_TOP;
            reg_lo = 0;
            reg_hi = 0;
            vspan_lo = 0;
            vspan_hi = 0;
            vspan_valid = 1'b0;
            non_snp_seen = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [30:0] value);
            case (idx)
                CFG_SNP_PADDING:   snp_pad = value[15:0];
                CFG_INDEL_PADDING: indel_pad = value[15:0];
                CFG_EXT_LIMIT:     ext_limit = value[15:0];
                CFG_EMIT_REF_CONF: clip_to_region = value[0];
                CFG_NO_TRIM:       report_untrimmed = value[0];
                CFG_CONTIG_LENGTH: contig_len = value;
                default: ;
            endcase
        endfunction

        function longint lmin(longint a, longint b);
            return (a < b) ? a : b;
        endfunction

        function longint lmax(longint a, longint b);
            return (a > b) ? a : b;
        endfunction

        function void add_row(span_kind_t kind, logic inr, trim_status_t st,
                              logic [15:0] pad, longint s, longint e, logic eor);
            trim_row_t row;
            row.kind = kind;
            row.inr = inr;
            row.st = st;
            row.pad = pad;
            row.s = s[30:0];
            row.e = e[30:0];
            row.eor = eor;
            expected_rows.push_back(row);
        endfunction

        function void note_item(op_t op, logic [30:0] ps_in, logic [30:0] pe_in,
                                logic snp, logic lst);
            longint      ps;
            longint      pe;
            longint      clen;
            longint      ext;
            longint      pd;
            longint      max_lo;
            longint      max_hi;
            longint      id_lo;
            longint      id_hi;
            longint      fin_lo;
            longint      fin_hi;
            longint      c_lo;
            longint      c_hi;
            logic [15:0] pad;
            bit          ov;
            bit          pre;
            bit          post;
            ps = longint'(ps_in);
            pe = longint'(pe_in);
            clen = longint'(contig_len);
            if (op == OP_HEADER)
            begin
                reg_lo = ps;
                reg_hi = pe;
                vspan_valid = 1'b0;
                vspan_lo = 0;
                vspan_hi = 0;
                non_snp_seen = 1'b0;
                if (lst)
                    add_row(KIND_SUMMARY, 1'b0, STATUS_NONE, snp_pad, 0, 0, 1'b1);
                return;
            end

            // State is never cleared by an outcome, only by a header.
            ov = (ps <= reg_hi) && (reg_lo <= pe);
            if (ov)
            begin
                if (!snp)
                    non_snp_seen = 1'b1;
                if (vspan_valid)
                begin
                    vspan_lo = lmin(vspan_lo, ps);
                    vspan_hi = lmax(vspan_hi, pe);
                end
                else
                begin
                    vspan_lo = ps;
                    vspan_hi = pe;
                    vspan_valid = 1'b1;
                end
            end
            add_row(KIND_VERDICT, ov, STATUS_NONE, 16'd0, ps, pe, 1'b0);
            if (!lst)
                return;

            pad = non_snp_seen ? indel_pad : snp_pad;
            if (!vspan_valid)
            begin
                add_row(KIND_SUMMARY, 1'b0, STATUS_NONE, pad, 0, 0, 1'b1);
                return;
            end
            if (report_untrimmed)
            begin
                add_row(KIND_SUMMARY, 1'b0, STATUS_UNTRIMMED, pad, 0, 0, 1'b1);
                return;
            end

            ext = longint'(ext_limit);
            pd = longint'(pad);
            max_lo = lmax(1, reg_lo - ext);
            max_hi = lmin(clen, reg_hi + ext);
            id_lo = lmax(1, vspan_lo - pd);
            id_hi = lmin(clen, vspan_hi + pd);
            fin_lo = lmin(lmax(max_lo, id_lo), vspan_lo);
            fin_hi = lmax(lmin(max_hi, id_hi), vspan_hi);
            c_lo = vspan_lo;
            c_hi = vspan_hi;
            if (clip_to_region)
            begin
                c_lo = lmax(c_lo, reg_lo);
                c_hi = lmin(c_hi, reg_hi);
            end
            pre = reg_lo < c_lo;
            post = reg_hi > c_hi;

            add_row(KIND_VARIANT, 1'b0, STATUS_TRIMMED, pad, vspan_lo, vspan_hi, 1'b0);
            add_row(KIND_MAXIMUM, 1'b0, STATUS_TRIMMED, pad, max_lo, max_hi, 1'b0);
            add_row(KIND_IDEAL, 1'b0, STATUS_TRIMMED, pad, id_lo, id_hi, 1'b0);
            add_row(KIND_FINAL, 1'b0, STATUS_TRIMMED, pad, fin_lo, fin_hi, !(pre || post));
            if (pre)
                add_row(KIND_FLANK, 1'b0, STATUS_TRIMMED, pad, reg_lo, c_lo - 1, !post);
            if (post)
                add_row(KIND_FLANK, 1'b1, STATUS_TRIMMED, pad, c_hi + 1, reg_hi, 1'b1);
        endfunction

        function void check_row(trim_row_t got);
            trim_row_t want;
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: kind %0d inr %0d status %0d pad %0d span %0d..%0d eor %0d",
                             got.kind, got.inr, got.st, got.pad, got.s, got.e, got.eor);
                return;
            end
            want = expected_rows.pop_front();
            if (got.kind !== want.kind || got.inr !== want.inr || got.st !== want.st ||
                got.pad !== want.pad || got.s !== want.s || got.e !== want.e ||
                got.eor !== want.eor)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("mismatch: expected kind %0d inr %0d status %0d pad %0d span %0d..%0d eor %0d",
                             want.kind, want.inr, want.st, want.pad, want.s, want.e, want.eor);
                    $display("          actual   kind %0d inr %0d status %0d pad %0d span %0d..%0d eor %0d",
                             got.kind, got.inr, got.st, got.pad, got.s, got.e, got.eor);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic        push;
    logic        full;
    logic        operation;
    logic [POS_W-1:0] pos_start;
    logic [POS_W-1:0] pos_end;
    logic        is_snp;
    logic        last;
    logic        empty;
    logic        pop;
    logic [2:0]  span_kind;
    logic        in_region;
    logic [1:0]  status;
    logic [PAD_W-1:0] padding_used;
    logic [POS_W-1:0] span_start;
    logic [POS_W-1:0] span_end;
    logic        end_of_run;

    trim_scoreboard board;
    int          burst_left;
    int          cycle_count;
    logic [30:0] cur_clen;

    assembly_region_trim_spans_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .pos_start    (pos_start),
        .pos_end      (pos_end),
        .is_snp       (is_snp),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .span_kind    (span_kind),
        .in_region    (in_region),
        .status       (status),
        .padding_used (padding_used),
        .span_start   (span_start),
        .span_end     (span_end),
        .end_of_run   (end_of_run)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: calm stretches that pop every cycle alternate with stretches of
    // random pops and stall runs.
    initial
    begin
        int  stall_left;
        int  mode_left;
        bit  calm;
        trim_row_t got;
        stall_left = 0;
        mode_left = 0;
        calm = 1'b0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.kind = span_kind;
                got.inr = in_region;
                got.st = status;
                got.pad = padding_used;
                got.s = span_start;
                got.e = span_end;
                got.eor = end_of_run;
                board.check_row(got);
            end
            if (mode_left == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = int'($urandom_range(20, 200));
            end
            mode_left--;
            if (calm)
                pop <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = int'($urandom_range(1, 12));
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic drive_item(op_t op, logic [30:0] ps, logic [30:0] pe,
                              logic snp, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 100))
                                                     : int'($urandom_range(1, 12));
            gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 30))
                                              : int'($urandom_range(0, 4));
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b1;
        operation <= op;
        pos_start <= ps;
        pos_end <= pe;
        is_snp <= snp;
        last <= lst;
        do @(posedge clk); while (full);
        board.note_item(op, ps, pe, snp, lst);
        burst_left--;
    endtask

    // Holds the sender until every expected row has come, then lets a header
    // without a result drain from the pipeline.
    task automatic wait_idle();
        push <= 1'b0;
        burst_left = 0;
        while (board.expected_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [30:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        board.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic apply_config(logic [15:0] snp_pad, logic [15:0] indel_pad,
                                logic [15:0] ext, logic clip, logic untrimmed,
                                logic [30:0] clen);
        write_reg(CFG_SNP_PADDING, {15'd0, snp_pad});
        write_reg(CFG_INDEL_PADDING, {15'd0, indel_pad});
        write_reg(CFG_EXT_LIMIT, {15'd0, ext});
        write_reg(CFG_EMIT_REF_CONF, {30'd0, clip});
        write_reg(CFG_NO_TRIM, {30'd0, untrimmed});
        write_reg(CFG_CONTIG_LENGTH, clen);
        cfg_we <= 1'b0;
        cur_clen = clen;
    endtask

    function automatic longint pick_pos();
        int     r;
        longint p;
        r = int'($urandom_range(0, 1500));
        case ($urandom_range(0, 3))
            0:       p = longint'(r) + 1;
            1:       p = longint'($urandom()) & POS_MAX;
            2:       p = POS_MAX - longint'(r);
            default: p = longint'(cur_clen) - longint'(r / 2);
        endcase
        if (p < 1)
            p = 1;
        return p;
    endfunction

    function automatic logic [30:0] clamp_pos(longint p);
        longint c;
        c = (p < 1) ? 1 : ((p > POS_MAX) ? POS_MAX : p);
        return c[30:0];
    endfunction

    // A region: header, up to six variants around it, some reversed, last on the final item.
    task automatic send_region(output int sent);
        longint lo;
        longint hi;
        longint vs;
        longint ve;
        longint swap_tmp;
        int     span_len;
        int     nvar;
        logic   snp;
        lo = pick_pos();
        span_len = int'($urandom_range(0, 400));
        hi = lo + longint'(span_len);
        nvar = int'($urandom_range(0, 6));
        drive_item(OP_HEADER, clamp_pos(lo), clamp_pos(hi), 1'($urandom), nvar == 0);
        for (int i = 0; i < nvar; i++)
        begin
            vs = lo + longint'(int'($urandom_range(0, span_len + 120))) - 60;
            snp = ($urandom_range(0, 2) != 0);
            ve = vs + (snp ? 0 : longint'($urandom_range(0, 40)));
            if ($urandom_range(0, 19) == 0)
            begin
                swap_tmp = vs;
                vs = ve + 1;
                ve = swap_tmp;
            end
            drive_item(OP_VARIANT, clamp_pos(vs), clamp_pos(ve), snp, i == nvar - 1);
        end
        sent = nvar + 1;
    endtask

    initial
    begin
        int phase_sent;
        int per_phase;
        int sent;
        bit paused;
        logic [15:0] pa;
        logic [15:0] pb;
        logic [15:0] pc;
        logic [30:0] clen;
        board = new();
        burst_left = 0;
        cycle_count = 0;
        cur_clen = POS_TOP;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SNP_PADDING;
        cfg_data <= '0;
        push <= 1'b0;
        operation <= OP_HEADER;
        pos_start <= '0;
        pos_end <= '0;
        is_snp <= 1'b0;
        last <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values. A variant with no header since reset
        // is judged against the cleared region, position 0 included.
        drive_item(OP_VARIANT, 31'd0, 31'd5, 1'b1, 1'b1);
        drive_item(OP_VARIANT, 31'd3, 31'd4, 1'b0, 1'b0);
        drive_item(OP_HEADER, 31'd100, 31'd200, 1'b0, 1'b1);
        drive_item(OP_HEADER, 31'd100, 31'd200, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd50, 31'd60, 1'b1, 1'b0);
        drive_item(OP_VARIANT, 31'd250, 31'd260, 1'b0, 1'b1);

        wait_idle();
        apply_config(16'd5, 16'd40, 16'd100, 1'b0, 1'b1, POS_TOP);
        drive_item(OP_HEADER, 31'd1000, 31'd2000, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd1500, 31'd1500, 1'b1, 1'b1);
        drive_item(OP_HEADER, 31'd1000, 31'd2000, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd1, 31'd2, 1'b0, 1'b1);

        // Widest paddings with a short contig: every expansion of the first region clamps, and a
        // second region starts beyond the contig end.
        wait_idle();
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 31'd1000);
        drive_item(OP_HEADER, 31'd10, 31'd900, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd5, 31'd20, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd800, 31'd1200, 1'b1, 1'b1);
        drive_item(OP_HEADER, POS_TOP, POS_TOP, 1'b1, 1'b0);
        drive_item(OP_VARIANT, POS_TOP, POS_TOP, 1'b1, 1'b1);

        wait_idle();
        apply_config(16'd3, 16'd7, 16'd0, 1'b0, 1'b0, POS_TOP);
        drive_item(OP_HEADER, 31'd500, 31'd600, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd550, 31'd560, 1'b1, 1'b1);
        drive_item(OP_HEADER, 31'd500, 31'd600, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd400, 31'd700, 1'b0, 1'b1);
        drive_item(OP_HEADER, 31'd500, 31'd600, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd580, 31'd520, 1'b1, 1'b1);
        drive_item(OP_HEADER, 31'd1, 31'd1, 1'b0, 1'b0);
        drive_item(OP_HEADER, 31'd1, POS_TOP, 1'b0, 1'b0);
        drive_item(OP_VARIANT, 31'd1, POS_TOP, 1'b0, 1'b1);

        per_phase = RANDOM_ITEMS / PHASES;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            pa = 16'($urandom_range(0, 300));
            pb = 16'($urandom_range(0, 300));
            pc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500));
            clen = ($urandom_range(0, 1) == 0) ? POS_TOP
                                               : clamp_pos(longint'($urandom_range(1000, 32'h7FFF_FFFF)));
            case (phase)
                0: apply_config(16'd0, 16'd0, 16'd0, 1'b0, 1'b0, POS_TOP);
                1: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, POS_TOP);
                2: apply_config(pa, pb, pc, 1'($urandom), 1'b1, clen);
                3: apply_config(pa, pb, pc, 1'($urandom), 1'b0, 31'd1);
                default: apply_config(pa, pb, pc, 1'($urandom),
                                      ($urandom_range(0, 4) == 0), clen);
            endcase
            phase_sent = 0;
            paused = 1'b0;
            while (phase_sent < per_phase)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // Noise: any operation, any positions, any flags.
                    drive_item(op_t'($urandom_range(0, 1)), 31'($urandom), 31'($urandom),
                               1'($urandom), 1'($urandom));
                    sent = 1;
                end
                else
                    send_region(sent);
                phase_sent += sent;
                if (!paused && phase_sent >= per_phase / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        push <= 1'b0;
        while (board.expected_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (board.mismatches == 0 && board.expected_rows.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
